// ===== design/fba_pkg.sv =====
// Shared types, codes and constants for the frame bitmap allocator.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned PFN_W      = 20;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ENTRY_W    = 32;
  localparam int unsigned FRAME_IO_W = 15;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_W      = 16;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 16'd32768;

  localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOOP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  localparam logic [ENTRY_W-1:0] PTE_PRESENT    = 32'h0000_0001;
  localparam logic [ENTRY_W-1:0] PTE_FRAME_MASK = 32'hffff_f000;
  localparam logic [WORD_BITS-1:0] WORD_FULL    = 32'hffff_ffff;

  typedef enum logic [1:0] {
    RD_TGT,
    RD_FIRST,
    RD_NEXT
  } rd_sel_e;

  typedef enum logic [2:0] {
    RES_NOOP,
    RES_FULL,
    RES_RANGE,
    RES_MAP,
    RES_FREE,
    RES_ALLOC
  } res_sel_e;

  typedef struct packed {
    logic     in_ready;
    logic     capture;
    logic     clr_wr;
    rd_sel_e  rd_sel;
    logic     scan_start;
    logic     scan_step;
    logic     rmw_wr;
    logic     scan_wr;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] op;
    logic            present;
    logic            in_range;
    logic            words_zero;
    logic            word_full;
    logic            scan_last;
    logic            out_free;
  } sts_t;

  function automatic logic [ENTRY_W-1:0] make_pte(logic [PFN_W-1:0] pfn, logic kernel,
                                                   logic rw);
    return {pfn, 9'd0, ~kernel, rw, 1'b1};
  endfunction

endpackage

// ===== design/fba_ctrl.sv =====
// Controller state machine: clear pass, request decode, bitmap scan and result handoff.
`timescale 1ns / 1ps

module fba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  fba_pkg::sts_t sts_i,
  output fba_pkg::cmd_t cmd_o
);
  import fba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RMW   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel  = RD_TGT;
    cmd_o.res_sel = RES_NOOP;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_RESP;
        unique case (sts_i.op)
          OP_MAP: begin
            if (sts_i.in_range) begin
              state_d = S_RMW;
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_RANGE;
            end
          end
          OP_ALLOC: begin
            if (sts_i.present) begin
              cmd_o.res_load = 1'b1;
            end else if (sts_i.words_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_FULL;
            end else begin
              cmd_o.rd_sel     = RD_FIRST;
              cmd_o.scan_start = 1'b1;
              state_d = S_SCAN;
            end
          end
          OP_FREE: begin
            if (!sts_i.present) begin
              cmd_o.res_load = 1'b1;
            end else if (!sts_i.in_range) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_RANGE;
            end else begin
              state_d = S_RMW;
            end
          end
          default: cmd_o.res_load = 1'b1;
        endcase
      end
      S_RMW: begin
        cmd_o.rmw_wr   = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = (sts_i.op == OP_MAP) ? RES_MAP : RES_FREE;
        state_d = S_RESP;
      end
      S_SCAN: begin
        cmd_o.rd_sel = RD_NEXT;
        if (!sts_i.word_full) begin
          cmd_o.scan_wr  = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ALLOC;
          state_d = S_RESP;
        end else if (sts_i.scan_last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_FULL;
          state_d = S_RESP;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

// ===== design/fba_dp.sv =====
// Datapath: bitmap memory, request and result registers, limit and entry logic.
`timescale 1ns / 1ps

module fba_dp #(
  parameter int unsigned NUM_FRAMES = 32768
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fba_pkg::cmd_t                     cmd_i,
  output fba_pkg::sts_t                     sts_o,
  input  logic                              cfg_we_i,
  input  logic [fba_pkg::CFG_W-1:0]         cfg_frame_count_i,
  input  logic [fba_pkg::OP_W-1:0]          op_i,
  input  logic [fba_pkg::ENTRY_W-1:0]       entry_in_i,
  input  logic [fba_pkg::FRAME_IO_W-1:0]    frame_in_i,
  input  logic                              is_kernel_i,
  input  logic                              is_rw_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [fba_pkg::ENTRY_W-1:0]       entry_out_o,
  output logic [fba_pkg::FRAME_IO_W-1:0]    frame_out_o,
  output logic [fba_pkg::STATUS_W-1:0]      status_o
);
  import fba_pkg::*;

  localparam int unsigned NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned CNT_W     = $clog2(NUM_WORDS + 1);
  localparam int unsigned LIM_W     = $clog2(NUM_FRAMES + 1);
  localparam int unsigned FRAME_W   = ADDR_W + BIT_W;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  logic [CFG_W-1:0]      frame_count_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_inc;
  logic [OP_W-1:0]       op_q;
  logic [ENTRY_W-1:0]    entry_q;
  logic [FRAME_IO_W-1:0] frame_q;
  logic                  kernel_q, rw_q;

  logic [ENTRY_W-1:0]    res_entry_q, res_entry_d;
  logic [FRAME_IO_W-1:0] res_frame_q, res_frame_d;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic                  out_valid_q;
  logic [ENTRY_W-1:0]    out_entry_q;
  logic [FRAME_IO_W-1:0] out_frame_q;
  logic [STATUS_W-1:0]   out_status_q;

  logic [LIM_W-1:0]       lim;
  logic [LIM_W-BIT_W-1:0] words;
  logic [PFN_W-1:0]       tgt;
  logic [ADDR_W-1:0]      tgt_word;
  logic [BIT_W-1:0]       tgt_bit;
  logic [WORD_BITS-1:0]   tgt_mask;
  logic [ADDR_W-1:0]      raddr, waddr;
  logic [WORD_BITS-1:0]   wdata;
  logic                   we;
  logic [WORD_BITS-1:0]   rdata_inc, low_zero;
  logic [BIT_W-1:0]       bidx;
  logic [FRAME_W-1:0]     hit_frame;
  logic [PFN_W-1:0]       alloc_pfn;

  always_comb begin
    if (32'(frame_count_q) < 32'(NUM_FRAMES)) begin
      lim = LIM_W'(frame_count_q);
    end else begin
      lim = LIM_W'(NUM_FRAMES);
    end
  end

  assign words    = lim[LIM_W-1:BIT_W];
  assign tgt      = (op_q == OP_MAP) ? PFN_W'(frame_q) : entry_q[ENTRY_W-1:ENTRY_W-PFN_W];
  assign tgt_word = tgt[FRAME_W-1:BIT_W];
  assign tgt_bit  = tgt[BIT_W-1:0];
  assign tgt_mask = WORD_BITS'(1) << tgt_bit;
  assign cnt_inc  = cnt_q + CNT_W'(1);

  assign rdata_inc = rdata_q + WORD_BITS'(1);
  assign low_zero  = ~rdata_q & rdata_inc;

  always_comb begin
    bidx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_zero[i]) bidx = bidx | BIT_W'(i);
    end
  end

  assign hit_frame = {cnt_q[ADDR_W-1:0], bidx};
  assign alloc_pfn = PFN_W'(hit_frame);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_FIRST: raddr = '0;
      RD_NEXT:  raddr = cnt_inc[ADDR_W-1:0];
      default:  raddr = tgt_word;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[ADDR_W-1:0];
    wdata = '0;
    priority if (cmd_i.clr_wr) begin
      we = 1'b1;
    end else if (cmd_i.rmw_wr) begin
      we    = 1'b1;
      waddr = tgt_word;
      wdata = (op_q == OP_MAP) ? (rdata_q | tgt_mask) : (rdata_q & ~tgt_mask);
    end else if (cmd_i.scan_wr) begin
      we    = 1'b1;
      wdata = rdata_q | rdata_inc;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    cnt_d = cnt_q;
    priority if (cmd_i.clr_wr || cmd_i.scan_step) begin
      cnt_d = cnt_inc;
    end else if (cmd_i.scan_start || cmd_i.out_load) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      frame_count_q <= FRAME_COUNT_RST;
      out_valid_q   <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) frame_count_q <= cfg_frame_count_i;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    res_entry_d  = entry_q;
    res_frame_d  = '0;
    res_status_d = ST_NOOP;
    unique case (cmd_i.res_sel)
      RES_FULL: res_status_d = ST_FULL;
      RES_RANGE: begin
        res_entry_d  = (op_q == OP_MAP) ? '0 : entry_q;
        res_frame_d  = tgt[FRAME_IO_W-1:0];
        res_status_d = ST_RANGE;
      end
      RES_MAP: begin
        res_entry_d  = make_pte(tgt, kernel_q, rw_q);
        res_frame_d  = tgt[FRAME_IO_W-1:0];
        res_status_d = ST_DONE;
      end
      RES_FREE: begin
        res_entry_d  = entry_q & ~(PTE_FRAME_MASK | PTE_PRESENT);
        res_frame_d  = tgt[FRAME_IO_W-1:0];
        res_status_d = ST_DONE;
      end
      RES_ALLOC: begin
        res_entry_d  = make_pte(alloc_pfn, kernel_q, rw_q);
        res_frame_d  = alloc_pfn[FRAME_IO_W-1:0];
        res_status_d = ST_DONE;
      end
      default: res_status_d = ST_NOOP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_i;
      entry_q  <= entry_in_i;
      frame_q  <= frame_in_i;
      kernel_q <= is_kernel_i;
      rw_q     <= is_rw_i;
    end
    if (cmd_i.res_load) begin
      res_entry_q  <= res_entry_d;
      res_frame_q  <= res_frame_d;
      res_status_q <= res_status_d;
    end
    if (cmd_i.out_load) begin
      out_entry_q  <= res_entry_q;
      out_frame_q  <= res_frame_q;
      out_status_q <= res_status_q;
    end
  end

  assign sts_o.clr_last   = (cnt_q == CNT_W'(NUM_WORDS - 1));
  assign sts_o.op         = op_q;
  assign sts_o.present    = entry_q[0];
  assign sts_o.in_range   = (32'(tgt) < 32'(lim));
  assign sts_o.words_zero = (words == '0);
  assign sts_o.word_full  = (rdata_q == WORD_FULL);
  assign sts_o.scan_last  = (32'(cnt_inc) == 32'(words));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign entry_out_o = out_entry_q;
  assign frame_out_o = out_frame_q;
  assign status_o    = out_status_q;

endmodule

// ===== design/frame_bitmap_allocator.sv =====
// Top level of the bitmap physical frame allocator.
//
//   channel | direction | signals
//   --------+-----------+-----------------------------------------------------
//   in      | request   | in_valid_i/in_ready_o, op, entry_in, frame_in, flags
//   out     | result    | out_valid_o/out_ready_i, entry_out, frame_out, status
//   cfg     | write     | cfg_valid_i/cfg_ready_o, cfg_frame_count_i
//
// Map and free go through the check, read-modify-write and result states between accepts;
// out-of-range and no-op requests skip the write. Alloc reads bitmap words one per cycle from the
// single read port until it finds a free bit or reaches the last word.
// After reset a clearing pass writes one bitmap word per cycle, ceil(NUM_FRAMES/32) words
// in all, with in_ready_o low; cfg writes are always taken.
// A finished result waits in the output register while the next request is taken;
// the following result holds the block until that register drains.
`timescale 1ns / 1ps

module frame_bitmap_allocator #(
  parameter int unsigned NUM_FRAMES = 32768
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fba_pkg::CFG_W-1:0]      cfg_frame_count_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fba_pkg::OP_W-1:0]       op_i,
  input  logic [fba_pkg::ENTRY_W-1:0]    entry_in_i,
  input  logic [fba_pkg::FRAME_IO_W-1:0] frame_in_i,
  input  logic                           is_kernel_i,
  input  logic                           is_rw_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fba_pkg::ENTRY_W-1:0]    entry_out_o,
  output logic [fba_pkg::FRAME_IO_W-1:0] frame_out_o,
  output logic [fba_pkg::STATUS_W-1:0]   status_o
);
  import fba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cmd.in_ready;

  fba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fba_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_frame_count_i (cfg_frame_count_i),
    .op_i              (op_i),
    .entry_in_i        (entry_in_i),
    .frame_in_i        (frame_in_i),
    .is_kernel_i       (is_kernel_i),
    .is_rw_i           (is_rw_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .entry_out_o       (entry_out_o),
    .frame_out_o       (frame_out_o),
    .status_o          (status_o)
  );

endmodule

// ===== design/fba_checker.sv =====
// Port-level checker for the frame bitmap allocator and its bind.
`timescale 1ns / 1ps

module fba_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [fba_pkg::ENTRY_W-1:0]    entry_out_o,
  input logic [fba_pkg::FRAME_IO_W-1:0] frame_out_o,
  input logic [fba_pkg::STATUS_W-1:0]   status_o
);
  import fba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in work");

  a_noop_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NOOP || status_o == ST_FULL) |-> frame_out_o == '0)
    else $error("no-op or full result carries a frame number");

  a_done_pfn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DONE && entry_out_o[0] |->
      entry_out_o[26:12] == frame_out_o)
    else $error("entry frame field does not match reported frame");

  a_free_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DONE && !entry_out_o[0] |->
      entry_out_o[31:12] == '0)
    else $error("freed entry still holds a frame number");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for frame_bitmap_allocator with a bitmap-tracking scoreboard.
`timescale 1ns / 1ps

import fba_pkg::*;

typedef struct packed {
  logic [ENTRY_W-1:0]    entry;
  logic [FRAME_IO_W-1:0] frame;
  logic [STATUS_W-1:0]   status;
} frame_result_t;

class frame_tracker;
  localparam int unsigned FRAMES = 32768;

  bit [WORD_BITS-1:0] used_words [FRAMES/WORD_BITS];
  logic [CFG_W-1:0]   frame_count;
  frame_result_t      pending[$];
  int unsigned        failures;

  function new();
    foreach (used_words[i]) used_words[i] = '0;
    frame_count = FRAME_COUNT_RST;
    failures    = 0;
  endfunction

  function int unsigned limit();
    return (frame_count < FRAMES) ? int'(frame_count) : FRAMES;
  endfunction

  function logic [ENTRY_W-1:0] page_entry(int unsigned f, logic kernel, logic rw);
    logic [PFN_W-1:0] pfn;
    pfn = f[PFN_W-1:0];
    return {pfn, 9'd0, ~kernel, rw, 1'b1};
  endfunction

  function frame_result_t accept_request(logic [OP_W-1:0] op, logic [ENTRY_W-1:0] entry,
                                         logic [FRAME_IO_W-1:0] frame, logic kernel,
                                         logic rw);
    frame_result_t r;
    int unsigned   lim, words, f, w, b;
    bit            found;
    lim      = limit();
    r.entry  = entry;
    r.frame  = '0;
    r.status = ST_NOOP;
    found    = 1'b0;
    f        = 0;
    case (op)
      OP_MAP: begin
        r.frame = frame;
        if (frame >= lim) begin
          r.entry  = '0;
          r.status = ST_RANGE;
        end else begin
          used_words[frame >> 5][frame[4:0]] = 1'b1;
          r.entry  = page_entry(32'(frame), kernel, rw);
          r.status = ST_DONE;
        end
      end
      OP_ALLOC: begin
        if (!entry[0]) begin
          r.status = ST_FULL;
          words    = lim / WORD_BITS;
          for (w = 0; w < words && !found; w++)
            if (used_words[w] != WORD_FULL)
              for (b = 0; b < WORD_BITS && !found; b++)
                if (!used_words[w][b]) begin
                  f     = w * WORD_BITS + b;
                  found = 1'b1;
                end
          if (found) begin
            used_words[f >> 5][f % WORD_BITS] = 1'b1;
            r.entry  = page_entry(f, kernel, rw);
            r.frame  = f[FRAME_IO_W-1:0];
            r.status = ST_DONE;
          end
        end
      end
      OP_FREE: begin
        if (entry[0]) begin
          f       = 32'(entry[31:12]);
          r.frame = f[FRAME_IO_W-1:0];
          if (f >= lim) begin
            r.status = ST_RANGE;
          end else begin
            used_words[f >> 5][f % WORD_BITS] = 1'b0;
            r.entry  = entry & ~(PTE_FRAME_MASK | PTE_PRESENT);
            r.status = ST_DONE;
          end
        end
      end
      default: ;
    endcase
    pending.push_back(r);
    return r;
  endfunction

  function void check_result(logic [ENTRY_W-1:0] entry, logic [FRAME_IO_W-1:0] frame,
                             logic [STATUS_W-1:0] status);
    frame_result_t exp;
    if (pending.size() == 0) begin
      $error("result with no request outstanding: entry_out %h", entry);
      failures++;
      return;
    end
    exp = pending.pop_front();
    if (entry !== exp.entry) begin
      $error("entry_out: expected %h, got %h", exp.entry, entry);
      failures++;
    end
    if (frame !== exp.frame) begin
      $error("frame_out: expected %h, got %h", exp.frame, frame);
      failures++;
    end
    if (status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, status);
      failures++;
    end
  endfunction
endclass

module testbench;
  localparam int unsigned FRAMES      = 32768;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                  clk_i             = 1'b0;
  logic                  rst_ni            = 1'b0;
  logic                  cfg_valid_i       = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_frame_count_i = '0;
  logic                  in_valid_i        = 1'b0;
  logic                  in_ready_o;
  logic [OP_W-1:0]       op_i              = '0;
  logic [ENTRY_W-1:0]    entry_in_i        = '0;
  logic [FRAME_IO_W-1:0] frame_in_i        = '0;
  logic                  is_kernel_i       = 1'b0;
  logic                  is_rw_i           = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i       = 1'b0;
  logic [ENTRY_W-1:0]    entry_out_o;
  logic [FRAME_IO_W-1:0] frame_out_o;
  logic [STATUS_W-1:0]   status_o;

  frame_tracker       tracker = new();
  logic [ENTRY_W-1:0] live_entries[$];
  bit                 calm   = 1'b0;
  int unsigned        cycles = 0;

  frame_bitmap_allocator #(.NUM_FRAMES(FRAMES)) uut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) tracker.check_result(entry_out_o, frame_out_o, status_o);
    out_ready_i <= calm || ($urandom_range(99) >= 27);
  end

  task automatic write_frame_count(input logic [CFG_W-1:0] value);
    cfg_valid_i       <= 1'b1;
    cfg_frame_count_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i          <= 1'b0;
    tracker.frame_count = value;
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // leaves valid high on return; caller lowers it or drives the next request
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] entry,
                               input logic [FRAME_IO_W-1:0] frame, input logic kernel,
                               input logic rw);
    frame_result_t r;
    maybe_idle();
    in_valid_i  <= 1'b1;
    op_i        <= op;
    entry_in_i  <= entry;
    frame_in_i  <= frame;
    is_kernel_i <= kernel;
    is_rw_i     <= rw;
    do @(posedge clk_i); while (!in_ready_o);
    r = tracker.accept_request(op, entry, frame, kernel, rw);
    if (r.status == ST_DONE && op != OP_FREE) begin
      live_entries.push_back(r.entry);
      if (live_entries.size() > 64) void'(live_entries.pop_front());
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic alloc_fresh();
    logic [ENTRY_W-1:0] e;
    e = $urandom;
    e[0] = 1'b0;
    issue_request(OP_ALLOC, e, FRAME_IO_W'($urandom), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
  endtask

  task automatic random_request();
    int unsigned           roll, lim, idx;
    logic [ENTRY_W-1:0]    e;
    logic [FRAME_IO_W-1:0] f;
    roll = $urandom_range(99);
    lim  = tracker.limit();
    e    = $urandom;
    f    = FRAME_IO_W'($urandom);
    if (roll < 30) begin
      if (lim > 0 && $urandom_range(99) < 85) f = FRAME_IO_W'($urandom_range(lim - 1));
      issue_request(OP_MAP, e, f, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if (roll < 62) begin
      if ($urandom_range(99) < 90) e[0] = 1'b0;
      else e[0] = 1'b1;
      issue_request(OP_ALLOC, e, f, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if (roll < 95) begin
      if (live_entries.size() != 0 && $urandom_range(99) < 80) begin
        idx = $urandom_range(live_entries.size() - 1);
        e   = live_entries[idx];
        live_entries.delete(idx);
        e[11:1] = 11'($urandom);
      end
      issue_request(OP_FREE, e, f, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      issue_request(OP_UNUSED, e, f, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] settings [9];
    settings = '{16'd32, 16'd33, 16'd63, 16'd100, 16'd1000, 16'd31, 16'd32768,
                 16'd65535, 16'd0};
    settings[8] = CFG_W'($urandom);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_frame_count(16'd32768);

    issue_request(OP_MAP, '0, 15'd0, 1'b1, 1'b1);
    issue_request(OP_MAP, '1, 15'h7fff, 1'b0, 1'b0);
    issue_request(OP_ALLOC, 32'h0000_0000, '0, 1'b0, 1'b1);
    issue_request(OP_ALLOC, 32'hffff_ffff, '1, 1'b1, 1'b1);
    issue_request(OP_ALLOC, 32'hffff_fffe, '0, 1'b1, 1'b0);
    issue_request(OP_FREE, 32'h07ff_ffff, '0, 1'b0, 1'b0);
    issue_request(OP_FREE, 32'h0000_0ffe, '1, 1'b0, 1'b0);
    issue_request(OP_FREE, 32'hffff_f001, '0, 1'b1, 1'b1);
    issue_request(OP_FREE, 32'h0800_0fff, '0, 1'b0, 1'b1);
    issue_request(OP_UNUSED, 32'ha5a5_a5a5, 15'h7fff, 1'b1, 1'b1);
    issue_request(OP_MAP, '0, 15'd0, 1'b0, 1'b1);
    issue_request(OP_FREE, 32'h0000_0003, '0, 1'b0, 1'b0);
    issue_request(OP_FREE, 32'h0000_0003, '0, 1'b0, 1'b0);
    issue_request(OP_ALLOC, 32'h0000_0000, '0, 1'b0, 1'b0);
    wait_idle();

    write_frame_count(16'd0);
    issue_request(OP_MAP, '0, 15'd0, 1'b0, 1'b1);
    issue_request(OP_ALLOC, '0, '0, 1'b1, 1'b1);
    issue_request(OP_FREE, 32'h0000_1007, '0, 1'b0, 1'b0);
    wait_idle();

    // small pool: fill the only scanned word until the block reports full
    write_frame_count(16'd40);
    issue_request(OP_MAP, '0, 15'd39, 1'b1, 1'b0);
    issue_request(OP_MAP, '0, 15'd40, 1'b1, 1'b0);
    repeat (34) alloc_fresh();
    wait_idle();

    write_frame_count(16'hffff);
    issue_request(OP_MAP, '0, 15'h7fff, 1'b0, 1'b1);
    issue_request(OP_FREE, 32'h0800_0001, '0, 1'b0, 1'b0);
    wait_idle();

    foreach (settings[p]) begin
      write_frame_count(settings[p]);
      calm = (p == 4);
      repeat (52) random_request();
      wait_idle();
    end
    calm = 1'b0;

    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
